>>> src/dual_key_priority_table_core_assert.svh
// Assertion macros for the priority table core.
// Included by the top level; needs clk_i and rst_ni in scope.
`ifndef DUAL_KEY_PRIORITY_TABLE_CORE_ASSERT_SVH
`define DUAL_KEY_PRIORITY_TABLE_CORE_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define DKPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never hold at a clock edge outside reset.
`define DKPT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> src/dkpt_pkg.sv
// Package for the dual-key priority table: op and status codes, entry type.
// No dependencies.
package dkpt_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_POP_P = 4'd1, OP_POP_T = 4'd2, OP_PEEK_P = 4'd3,
    OP_PEEK_T = 4'd4, OP_CHG_P = 4'd5, OP_CHG_T = 4'd6, OP_LIST_P = 4'd7,
    OP_LIST_T = 4'd8
  } op_e;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StNoMatch = 2'd3;

  typedef struct packed {
    logic [7:0]  prio;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] tag;
    logic [31:0] stamp;
  } entry_t;

  // Controls handed to the compare unit.
  typedef struct packed {
    logic time_ord;
    logic have_best;
  } cmp_ctrl_t;

endpackage

>>> src/dkpt_cmp.sv
// Shared order comparator: does the candidate precede the current best?
// Depends on dkpt_pkg.
module dkpt_cmp #(
  parameter int unsigned IdxW = 4
) (
  input  dkpt_pkg::cmp_ctrl_t ctrl_i,
  input  dkpt_pkg::entry_t    cand_i,
  input  logic [IdxW-1:0]     cand_idx_i,
  input  dkpt_pkg::entry_t    best_i,
  input  logic [IdxW-1:0]     best_idx_i,
  output logic                wins_o
);
  import dkpt_pkg::*;

  logic [16:0] tc, tb;
  logic        kwin, keq;

  always_comb begin
    tc = {cand_i.hour, cand_i.minute, cand_i.second};
    tb = {best_i.hour, best_i.minute, best_i.second};
    if (ctrl_i.time_ord) begin
      keq  = (tc == tb);
      kwin = (tc < tb);
    end else begin
      keq  = (cand_i.prio == best_i.prio);
      kwin = (cand_i.prio > best_i.prio);
    end
    if (!ctrl_i.have_best) wins_o = 1'b1;
    else if (!keq) wins_o = kwin;
    else if (cand_i.stamp != best_i.stamp) wins_o = cand_i.stamp > best_i.stamp;
    else wins_o = cand_idx_i < best_idx_i;
  end

endmodule

>>> src/dual_key_priority_table_core.sv
// Top level of the dual-key priority table: sequencer, slot store, output register.
// Depends on dkpt_pkg, dkpt_cmp and dual_key_priority_table_core_assert.svh.
//
// Channel  Dir  Handshake                    Content
// s_axis   in   s_axis_tvalid/s_axis_tready  one operation request
// m_axis   out  m_axis_tvalid/m_axis_tready  result entries, tlast on the final one
//
// Every known request sweeps all slots with one comparator, one slot a cycle: add
// looks for the lowest free slot, the others for the best candidate. A list sweeps
// the table anew for each entry it returns. An unknown op is dropped at once.
// A stalled result holds the sequencer in its output step; s_axis_tready is high
// only while idle. Reset clears valid bits, stamp counter and control state.
module dual_key_priority_table_core #(
  parameter int unsigned TABLE_DEPTH = dkpt_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[3:0], priority_req[11:4], hour[16:12], minute[22:17], second[28:23],
  // tag[44:29], new_priority[52:45], new_hour[57:53], new_minute[63:58],
  // new_second[69:64], zero fill to 72
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_priority[9:2], out_hour[14:10], out_minute[20:15],
  // out_second[26:21], out_tag[42:27], zero fill to 48
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import dkpt_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_OUT} state_e;

  state_e               state_q;
  logic [71:0]          req_q;
  logic [TABLE_DEPTH-1:0] valid_q, skip_q;
  entry_t               mem_q [TABLE_DEPTH];
  logic [31:0]          stamp_q;
  logic [CntW-1:0]      idx_q;
  logic [IdxW-1:0]      best_idx_q;
  entry_t               best_q;
  logic                 have_q;
  logic                 out_valid_q, out_last_q;
  logic [47:0]          out_data_q;
  logic                 more_q;

  op_e         op;
  logic [16:0] req_time;
  logic        time_ord, is_list, match, cand_ok, wins, list_done;
  logic [IdxW-1:0] idx;
  entry_t      cand, upd;
  cmp_ctrl_t   cc;

  assign op       = op_e'(req_q[3:0]);
  assign req_time = {req_q[16:12], req_q[22:17], req_q[28:23]};
  assign time_ord = (op == OP_POP_T) || (op == OP_PEEK_T) || (op == OP_CHG_T) ||
                    (op == OP_LIST_T);
  assign is_list  = (op == OP_LIST_P) || (op == OP_LIST_T);
  assign idx      = idx_q[IdxW-1:0];
  assign cand     = mem_q[idx];
  assign cc       = '{time_ord: time_ord, have_best: have_q};
  // The entry just chosen is the only one not yet listed.
  assign list_done = ((valid_q & ~skip_q) == (TABLE_DEPTH'(1) << best_idx_q));

  always_comb begin
    if (op == OP_CHG_P) match = (cand.prio == req_q[11:4]);
    else if (op == OP_CHG_T) match = ({cand.hour, cand.minute, cand.second} == req_time);
    else match = 1'b1;
  end

  assign cand_ok = valid_q[idx] && !skip_q[idx] && match;

  dkpt_cmp #(.IdxW(IdxW)) u_cmp (
    .ctrl_i(cc), .cand_i(cand), .cand_idx_i(idx),
    .best_i(best_q), .best_idx_i(best_idx_q), .wins_o(wins)
  );

  always_comb begin
    upd = best_q;
    if (op == OP_CHG_P) upd.prio = req_q[52:45];
    if (op == OP_CHG_T) begin
      upd.hour   = req_q[57:53];
      upd.minute = req_q[63:58];
      upd.second = req_q[69:64];
    end
  end

  function automatic logic [47:0] pack_out(logic [1:0] st, entry_t e);
    return {5'd0, e.tag, e.second, e.minute, e.hour, e.prio, st};
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Entry store: no reset, only valid slots are read for results.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACT && have_q) begin
      if (op == OP_ADD)
        mem_q[best_idx_q] <= '{prio: req_q[11:4], hour: req_q[16:12],
                               minute: req_q[22:17], second: req_q[28:23],
                               tag: req_q[44:29], stamp: stamp_q};
      else if (op == OP_CHG_P || op == OP_CHG_T)
        mem_q[best_idx_q] <= upd;
    end
  end

  // The request is latched while idle; add keeps the first free slot, the others keep the best candidate.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) req_q <= s_axis_tdata;
    if (state_q == S_SCAN && idx_q < CntW'(TABLE_DEPTH) &&
        (op == OP_ADD ? (!valid_q[idx] && !have_q) : (cand_ok && wins))) begin
      best_q     <= cand;
      best_idx_q <= idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      skip_q      <= '0;
      stamp_q     <= '0;
      idx_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_data_q  <= '0;
      more_q      <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_ACT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            idx_q  <= '0;
            have_q <= 1'b0;
            skip_q <= '0;
            more_q <= 1'b0;
            if (s_axis_tdata[3:0] <= OP_LIST_T) state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_q == CntW'(TABLE_DEPTH)) begin
            state_q <= S_ACT;
          end else begin
            if (op == OP_ADD) begin
              if (!valid_q[idx] && !have_q) have_q <= 1'b1;
            end else if (cand_ok) begin
              have_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_ACT: begin
          if (!out_valid_q || m_axis_tready) begin
            if (op == OP_ADD) begin
              out_valid_q <= 1'b1;
              out_last_q  <= 1'b1;
              state_q     <= S_IDLE;
              if (have_q) begin
                valid_q[best_idx_q] <= 1'b1;
                stamp_q <= stamp_q + 32'd1;
                out_data_q <= pack_out(StOk, '{prio: req_q[11:4], hour: req_q[16:12],
                  minute: req_q[22:17], second: req_q[28:23], tag: req_q[44:29],
                  stamp: stamp_q});
              end else begin
                out_data_q <= pack_out(StFull, '0);
              end
            end else if (!have_q) begin
              state_q <= S_IDLE;
              if (is_list && more_q) begin
                out_valid_q <= 1'b0;
                out_last_q  <= 1'b0;
              end else begin
                out_valid_q <= 1'b1;
                out_last_q  <= 1'b1;
                if (valid_q == '0) out_data_q <= pack_out(StEmpty, '0);
                else out_data_q <= pack_out(StNoMatch, '0);
              end
            end else if (op == OP_CHG_P || op == OP_CHG_T) begin
              out_valid_q <= 1'b1;
              out_last_q  <= 1'b1;
              state_q     <= S_IDLE;
              out_data_q  <= pack_out(StOk, upd);
            end else begin
              out_valid_q <= 1'b1;
              out_data_q  <= pack_out(StOk, best_q);
              if (op == OP_POP_P || op == OP_POP_T) valid_q[best_idx_q] <= 1'b0;
              if (is_list && !list_done) begin
                out_last_q <= 1'b0;
                skip_q[best_idx_q] <= 1'b1;
                more_q  <= 1'b1;
                idx_q   <= '0;
                have_q  <= 1'b0;
                state_q <= S_SCAN;
              end else begin
                out_last_q <= 1'b1;
                state_q    <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "dual_key_priority_table_core_assert.svh"

  `DKPT_ASSERT(a_busy_not_ready, (state_q != S_IDLE) |-> !s_axis_tready, "ready while busy")
  `DKPT_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed under stall")
  `DKPT_ASSERT(a_stamp_step, (stamp_q != $past(stamp_q)) |-> (stamp_q == $past(stamp_q) + 32'd1), "stamp jumped")
  `DKPT_NEVER(a_idx_range, idx_q > CntW'(TABLE_DEPTH), "sweep index out of range")

endmodule
